// ----- hdl/dcf_pkg.sv -----
// Shared types and constants for the decimating complex FIR.
// Depends on nothing; dcf_mac and the top level import it.
`timescale 1ns / 1ps

package dcf_pkg;

  localparam int TAPS      = 64;
  localparam int PTR_W     = $clog2(TAPS);
  localparam int TAP_IDX_W = 6;
  localparam int SMP_W     = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SMP_W + COEF_W;
  localparam int ACC_W     = PROD_W + 1 + PTR_W;
  localparam int FRAC_SH   = 17;
  localparam int DF_W      = 9;
  localparam int CNT_W     = 8;
  localparam logic [DF_W-1:0] DF_MAX   = DF_W'(256);
  localparam logic [DF_W-1:0] DF_RESET = DF_W'(1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
  } smp_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
  } coef_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic                    sat;
  } mac_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

endpackage

// ----- hdl/dcf_store.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Per-entry valid bits make unwritten entries read as zero; no package needed.
`timescale 1ns / 1ps

module dcf_store #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [W-1:0]               wdata,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [W-1:0]               rdata
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- hdl/dcf_mac.sv -----
// Complex multiply-accumulate pipe with rounding and saturation of the sum.
// Depends on dcf_pkg for widths and the control and result structs.
`timescale 1ns / 1ps

module dcf_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  dcf_pkg::mac_ctl_t ctl,
  input  dcf_pkg::smp_t     smp,
  input  dcf_pkg::coef_t    coef,
  output logic              busy,
  output dcf_pkg::mac_res_t res
);
  import dcf_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_SH - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((2 ** (SMP_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);

  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                     pvld_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic [SMP_W:0]           rs_re, rs_im;

  function automatic logic [SMP_W:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] s;
    logic [SMP_W:0]          r;
    b = a + RND_BIAS;
    s = b >>> FRAC_SH;
    if (s > SAT_MAX) begin
      r = {1'b1, SAT_MAX[SMP_W-1:0]};
    end else if (s < SAT_MIN) begin
      r = {1'b1, SAT_MIN[SMP_W-1:0]};
    end else begin
      r = {1'b0, s[SMP_W-1:0]};
    end
    return r;
  endfunction

  // Products stage
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      p_rr_r <= smp.re * coef.re;
      p_ii_r <= smp.im * coef.im;
      p_ri_r <= smp.re * coef.im;
      p_ir_r <= smp.im * coef.re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.vld;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pvld_r) begin
      acc_re_r <= acc_re_r + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      acc_im_r <= acc_im_r + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  assign rs_re   = rnd_sat(acc_re_r);
  assign rs_im   = rnd_sat(acc_im_r);
  assign res.re  = rs_re[SMP_W-1:0];
  assign res.im  = rs_im[SMP_W-1:0];
  assign res.sat = rs_re[SMP_W] | rs_im[SMP_W];
  assign busy    = pvld_r;

endmodule

// ----- hdl/decimating_complex_fir.sv -----
// Top level of the decimating complex FIR: control sequencer, sample ring,
// coefficient store and MAC pipe. Depends on dcf_pkg, dcf_store and dcf_mac.
`timescale 1ns / 1ps

// A beat with in_command low pushes one I/Q sample into a TAPS-entry ring; a
// beat with in_command high loads one complex Q1.17 coefficient at in_tap_index
// (indices at or beyond TAPS are dropped). Every decimation_factor-th sample
// (factor 0 acts as 1, above 256 as 256) starts one output: the exact complex
// sum over all taps of coefficient k times the sample k places back, rounded
// half up by 2^16, shifted right by 17 and clipped to 16 bits, out_saturated
// flagging a clip on either part. Loads and samples that give no output leave
// in_ready high. A sample that gives an output holds in_ready low while one
// shared complex multiply-accumulate walks the taps one per cycle, reading both
// synchronous memories at one port each; then the read and product registers
// drain, and once the output register is free the rounded sum is loaded into it.
// The output register lets the next beat in while a result waits. Both stores
// come out of reset reading as zero through per-entry valid bits, so there is
// no clearing pass. cfg_wdata sets decimation_factor (reset 1); write it only
// while the block is idle.
module decimating_complex_fir (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic        [dcf_pkg::TAP_IDX_W-1:0] in_tap_index,
  input  logic signed [dcf_pkg::COEF_W-1:0]    in_coef_re,
  input  logic signed [dcf_pkg::COEF_W-1:0]    in_coef_im,
  input  logic signed [dcf_pkg::SMP_W-1:0]     in_sample_re,
  input  logic signed [dcf_pkg::SMP_W-1:0]     in_sample_im,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dcf_pkg::SMP_W-1:0]     out_re,
  output logic signed [dcf_pkg::SMP_W-1:0]     out_im,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic        [dcf_pkg::DF_W-1:0]      cfg_wdata
);
  import dcf_pkg::*;

  state_t           st_r, st_nxt;
  logic [DF_W-1:0]  df_r;
  logic [DF_W-1:0]  df_sat;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W:0]   cnt_inc;
  logic [PTR_W-1:0] wp_r, pos_r, k_r;
  logic             rd_vld_r;
  logic             accept, push, fire, load_ok;
  logic             issue, out_load;
  logic             out_valid_r;
  logic signed [SMP_W-1:0] out_re_r, out_im_r;
  logic             out_sat_r;
  smp_t             wr_smp, rd_smp;
  coef_t            wr_coef, rd_coef;
  mac_ctl_t         mac_ctl;
  mac_res_t         mac_res;
  logic             mac_busy;

  // Input beats are taken only between outputs; this is the interlock that
  // keeps writes off the stores while the tap walk reads them.
  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign push     = accept & (in_command == CMD_PUSH);
  assign load_ok  = accept & (in_command == CMD_LOAD) & (32'(in_tap_index) < TAPS);

  // Clamp the factor; zero needs no special handling as count + 1 always reaches it
  assign df_sat  = (df_r > DF_MAX) ? DF_MAX : df_r;
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign fire    = push & (cnt_inc >= df_sat);

  assign wr_smp.re  = in_sample_re;
  assign wr_smp.im  = in_sample_im;
  assign wr_coef.re = in_coef_re;
  assign wr_coef.im = in_coef_im;

  dcf_store #(
    .W     (2 * SMP_W),
    .DEPTH (TAPS)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (push),
    .waddr (wp_r),
    .wdata (wr_smp),
    .rd_en (issue),
    .raddr (pos_r),
    .rdata (rd_smp)
  );

  dcf_store #(
    .W     (2 * COEF_W),
    .DEPTH (TAPS)
  ) u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (load_ok),
    .waddr (PTR_W'(in_tap_index)),
    .wdata (wr_coef),
    .rd_en (issue),
    .raddr (k_r),
    .rdata (rd_coef)
  );

  assign mac_ctl.clear = fire;
  assign mac_ctl.vld   = rd_vld_r;

  dcf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .smp   (rd_smp),
    .coef  (rd_coef),
    .busy  (mac_busy),
    .res   (mac_res)
  );

  // Sequencer: walk the taps, drain the pipe, hand over to the output register
  always_comb begin
    st_nxt   = st_r;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (fire) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (k_r == PTR_W'(TAPS - 1)) begin
          st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!rd_vld_r && !mac_busy) begin
          st_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      df_r        <= DF_RESET;
      cnt_r       <= '0;
      wp_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= issue;
      if (cfg_we) begin
        df_r <= cfg_wdata;
      end
      // Advance the ring position on every sample, output or not
      if (push) begin
        cnt_r <= fire ? '0 : cnt_inc[CNT_W-1:0];
        wp_r  <= (wp_r == PTR_W'(TAPS - 1)) ? '0 : wp_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tap walk: newest sample first, going back round the ring
  always_ff @(posedge clk) begin
    if (fire) begin
      k_r   <= '0;
      pos_r <= wp_r;
    end else if (issue) begin
      k_r   <= k_r + 1'b1;
      pos_r <= (pos_r == '0) ? PTR_W'(TAPS - 1) : pos_r - 1'b1;
    end
  end

  // Hold the result until its beat goes out
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r  <= mac_res.re;
      out_im_r  <= mac_res.im;
      out_sat_r <= mac_res.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_re        = out_re_r;
  assign out_im        = out_im_r;
  assign out_saturated = out_sat_r;

  // No beat is taken while reads or products are still in flight
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!rd_vld_r && !mac_busy))
    else $error("input beat taken while the MAC pipe is busy");

  // The output register is never overwritten while holding an untaken result
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // The walk ends after the last tap
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && k_r == PTR_W'(TAPS - 1)) |=> (st_r == ST_FLUSH))
    else $error("tap walk did not stop at the last tap");

  // Rounding reads a settled sum only
  a_finish_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FINISH) |-> (!rd_vld_r && !mac_busy && !issue))
    else $error("result taken before the sum settled");

endmodule
